// ===== rtl/transform_matrix_stack_unit_core_assert.svh =====
// assertion macros used by the rtl control unit
`ifndef TRANSFORM_MATRIX_STACK_UNIT_CORE_ASSERT_SVH
`define TRANSFORM_MATRIX_STACK_UNIT_CORE_ASSERT_SVH

// expr must never hold
`define TMSU_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("tmsu assertion failed");

// cons must hold in the cycle after ante
`define TMSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tmsu assertion failed");

`endif

// ===== rtl/tmsu_pkg.sv =====
package tmsu_pkg;

    localparam logic [2:0] FN_IDENTITY  = 3'd0;
    localparam logic [2:0] FN_TRANSLATE = 3'd1;
    localparam logic [2:0] FN_SCALE     = 3'd2;
    localparam logic [2:0] FN_ORTHO     = 3'd3;
    localparam logic [2:0] FN_FRUSTUM   = 3'd4;
    localparam logic [2:0] FN_PUSH      = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO_DIV = 2'd3;

    localparam logic [2:0] DIV_LAST = 3'd5;
    localparam logic [3:0] ELEM_LAST = 4'd15;
    localparam logic [6:0] MAC_LAST = 7'd65;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_LOAD, S_BASE, S_FE, S_FE2, S_DIVGO, S_DIVWAIT,
        S_MAC, S_WRITE, S_RSTART, S_RLOAD, S_EMIT
    } state_t;

    typedef enum logic {
        WR_IDENT,
        WR_COPY
    } wr_src_t;

    typedef struct packed {
        logic       capture;
        logic [2:0] func;
        logic       rd_en;
        logic       wr_en;
        wr_src_t    wr_src;
        logic [3:0] elem;
        logic       t_zero;
        logic       base_en;
        logic       mul_en;
        logic       mul_fe;
        logic [5:0] mul_idx;
        logic       div_start;
        logic [2:0] div_sel;
        logic [1:0] row;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_div;
        logic div_done;
    } dp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v[65:31] == {35{v[31]}}) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    function automatic logic [3:0] div_target(input logic frust, input logic [2:0] sel);
        logic [3:0] t;
        case (sel)
            3'd0: t = 4'd0;
            3'd1: t = 4'd5;
            3'd2: t = 4'd10;
            3'd3: t = frust ? 4'd2 : 4'd3;
            3'd4: t = frust ? 4'd6 : 4'd7;
            default: t = 4'd11;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/tmsu_div.sv =====
module tmsu_div import tmsu_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [32:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int CNTW = $clog2(NW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   sh_reg;
    logic [32:0]     rem_reg;
    logic [32:0]     d_reg;
    logic [32:0]     q_reg;
    logic            ovf_reg;
    logic            neg_reg;

    logic [63:0] nmag;
    logic [32:0] dmag;
    logic [34:0] trial;
    logic        big;

    assign nmag  = num[63] ? 64'(-num) : 64'(num);
    assign dmag  = den[32] ? 33'(-den) : 33'(den);
    assign trial = {1'b0, rem_reg, sh_reg[NW-1]} - {2'b00, d_reg};
    assign big   = ovf_reg || q_reg[32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= {nmag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            d_reg   <= dmag;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= num[63] ^ den[32];
        end else if (busy_reg) begin
            if (!trial[34]) begin
                rem_reg <= trial[32:0];
            end else begin
                rem_reg <= {rem_reg[31:0], sh_reg[NW-1]};
            end
            q_reg   <= {q_reg[31:0], ~trial[34]};
            ovf_reg <= ovf_reg | q_reg[32];
            sh_reg  <= {sh_reg[NW-2:0], 1'b0};
        end
    end

    always_comb begin
        if (!neg_reg) begin
            quo = (big || q_reg[31]) ? 32'sh7fff_ffff : $signed(q_reg[31:0]);
        end else begin
            quo = (big || (q_reg[31] && (|q_reg[30:0]))) ? 32'sh8000_0000
                                                         : $signed(-q_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/tmsu_dp.sv =====
module tmsu_dp import tmsu_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int SW = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] s_arg_a,
    input  logic signed [31:0] s_arg_b,
    input  logic signed [31:0] s_arg_c,
    input  logic signed [31:0] s_arg_d,
    input  logic signed [31:0] s_arg_e,
    input  logic signed [31:0] s_arg_f,
    input  dp_cmd_t            cmd,
    input  logic               stk,
    input  logic [SW-1:0]      rd_slot,
    input  logic [SW-1:0]      wr_slot,
    output dp_sts_t            sts,
    output logic signed [31:0] m_col_zero,
    output logic signed [31:0] m_col_one,
    output logic signed [31:0] m_col_two,
    output logic signed [31:0] m_col_three
);

    localparam int AW = SW + 5;
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    logic signed [31:0] mem [2**AW];

    logic signed [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    logic signed [31:0] t_reg [16];
    logic signed [31:0] m_reg [16];
    logic signed [31:0] m_base [16];
    logic signed [63:0] prod_reg;
    logic signed [63:0] fe_reg;
    logic signed [65:0] acc_reg;
    logic               p_v_reg, p_fe_reg, a_v_reg;
    logic [1:0]         p_k_reg;
    logic [3:0]         p_ij_reg, a_ij_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_sh;
    logic [AW-1:0]      raddr, waddr;
    logic               we;
    logic signed [31:0] wdata;
    logic signed [32:0] bma, dmc, fme, bpa, dpc, fpe;
    logic signed [63:0] div_num;
    logic signed [32:0] div_den;
    logic               div_done;
    logic signed [31:0] div_q;
    logic               frust;

    assign frust = (cmd.func == FN_FRUSTUM);

    assign bma = {b_reg[31], b_reg} - {a_reg[31], a_reg};
    assign dmc = {d_reg[31], d_reg} - {c_reg[31], c_reg};
    assign fme = {f_reg[31], f_reg} - {e_reg[31], e_reg};
    assign bpa = {b_reg[31], b_reg} + {a_reg[31], a_reg};
    assign dpc = {d_reg[31], d_reg} + {c_reg[31], c_reg};
    assign fpe = {f_reg[31], f_reg} + {e_reg[31], e_reg};

    always_comb begin
        case (cmd.div_sel)
            3'd0, 3'd3: div_den = bma;
            3'd1, 3'd4: div_den = dmc;
            default:    div_den = fme;
        endcase
        case (cmd.div_sel)
            3'd0, 3'd1: div_num = frust ? {{31{e_reg[31]}}, e_reg, 1'b0}
                                        : 64'(ONE) <<< 1;
            3'd2:       div_num = frust ? -{{31{fpe[32]}}, fpe}
                                        : -(64'(ONE) <<< 1);
            3'd3:       div_num = frust ? {{31{bpa[32]}}, bpa} : -{{31{bpa[32]}}, bpa};
            3'd4:       div_num = frust ? {{31{dpc[32]}}, dpc} : -{{31{dpc[32]}}, dpc};
            default:    div_num = frust ? -(fe_reg <<< 1) : -{{31{fpe[32]}}, fpe};
        endcase
    end

    tmsu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_q)
    );

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (frust) begin
                m_base[i] = '0;
            end else if (i == 0 || i == 5 || i == 10 || i == 15) begin
                m_base[i] = ONE;
            end else begin
                m_base[i] = '0;
            end
        end
        case (cmd.func)
            FN_TRANSLATE: begin
                m_base[3]  = a_reg;
                m_base[7]  = b_reg;
                m_base[11] = c_reg;
            end
            FN_SCALE: begin
                m_base[0]  = a_reg;
                m_base[5]  = b_reg;
                m_base[10] = c_reg;
            end
            FN_FRUSTUM: begin
                m_base[14] = -ONE;
            end
            default: begin
            end
        endcase
    end

    assign mul_a = cmd.mul_fe ? f_reg : t_reg[{cmd.mul_idx[5:4], cmd.mul_idx[1:0]}];
    assign mul_b = cmd.mul_fe ? e_reg : m_reg[{cmd.mul_idx[1:0], cmd.mul_idx[3:2]}];
    assign prod_sh = prod_reg >>> FRAC_BITS;

    assign raddr = {stk, rd_slot, cmd.elem};
    assign we    = a_v_reg || cmd.wr_en;
    assign waddr = {stk, wr_slot, a_v_reg ? a_ij_reg : cmd.elem};

    always_comb begin
        if (a_v_reg) begin
            wdata = sat32(acc_reg);
        end else if (cmd.wr_src == WR_COPY) begin
            wdata = t_reg[cmd.elem];
        end else begin
            wdata = (cmd.elem[1:0] == cmd.elem[3:2]) ? ONE : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            a_reg <= s_arg_a;
            b_reg <= s_arg_b;
            c_reg <= s_arg_c;
            d_reg <= s_arg_d;
            e_reg <= s_arg_e;
            f_reg <= s_arg_f;
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.t_zero) begin
            for (int i = 0; i < 16; i++) begin
                t_reg[i] <= '0;
            end
        end else if (cmd.rd_en) begin
            t_reg[cmd.elem] <= mem[raddr];
        end
        if (cmd.base_en) begin
            for (int i = 0; i < 16; i++) begin
                m_reg[i] <= m_base[i];
            end
        end else if (div_done) begin
            m_reg[div_target(frust, cmd.div_sel)] <= div_q;
        end
        prod_reg <= mul_a * mul_b;
        p_k_reg  <= cmd.mul_idx[1:0];
        p_ij_reg <= cmd.mul_idx[5:2];
        if (p_v_reg) begin
            acc_reg <= ((p_k_reg == 2'd0) ? 66'sd0 : acc_reg)
                       + {{2{prod_sh[63]}}, prod_sh};
        end
        a_ij_reg <= p_ij_reg;
        if (p_fe_reg) begin
            fe_reg <= prod_sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg  <= 1'b0;
            p_fe_reg <= 1'b0;
            a_v_reg  <= 1'b0;
        end else begin
            p_v_reg  <= cmd.mul_en;
            p_fe_reg <= cmd.mul_fe;
            a_v_reg  <= p_v_reg && (p_k_reg == 2'd3);
        end
    end

    assign sts.zero_div = (a_reg == b_reg) || (c_reg == d_reg) || (e_reg == f_reg);
    assign sts.div_done = div_done;

    assign m_col_zero  = t_reg[{cmd.row, 2'd0}];
    assign m_col_one   = t_reg[{cmd.row, 2'd1}];
    assign m_col_two   = t_reg[{cmd.row, 2'd2}];
    assign m_col_three = t_reg[{cmd.row, 2'd3}];

endmodule

// ===== rtl/tmsu_ctrl.sv =====
`include "transform_matrix_stack_unit_core_assert.svh"

module tmsu_ctrl import tmsu_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int SW = 5,
    parameter int CW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_func,
    input  logic          s_which_stack,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_row_index,
    output logic          m_last_row,
    output logic [1:0]    m_status,
    output dp_cmd_t       cmd,
    input  dp_sts_t       sts,
    output logic          stk,
    output logic [SW-1:0] rd_slot,
    output logic [SW-1:0] wr_slot
);

    state_t        state_reg, state_next;
    logic [6:0]    idx_reg, idx_next;
    logic [2:0]    func_reg, func_next;
    logic          stk_reg, stk_next;
    logic [1:0]    status_reg, status_next;
    logic [2:0]    sel_reg, sel_next;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic [CW-1:0] cur_cnt;
    logic          empty;
    logic          is_push;

    assign cur_cnt = cnt_reg[stk_reg];
    assign empty   = (cur_cnt == '0);
    assign is_push = (func_reg == FN_PUSH);
    assign stk     = stk_reg;
    assign rd_slot = SW'(cur_cnt - CW'(1));
    assign wr_slot = is_push ? SW'(cur_cnt) : SW'(cur_cnt - CW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            func_reg   <= FN_IDENTITY;
            stk_reg    <= 1'b0;
            status_reg <= ST_OK;
            sel_reg    <= '0;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            func_reg   <= func_next;
            stk_reg    <= stk_next;
            status_reg <= status_next;
            sel_reg    <= sel_next;
            cnt_reg[0] <= cnt_next[0];
            cnt_reg[1] <= cnt_next[1];
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        func_next   = func_reg;
        stk_next    = stk_reg;
        status_next = status_reg;
        sel_next    = sel_reg;
        cnt_next[0] = cnt_reg[0];
        cnt_next[1] = cnt_reg[1];
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next   = s_func;
                    stk_next    = s_which_stack;
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (func_reg == FN_IDENTITY) begin
                    if (empty) begin
                        cnt_next[stk_reg] = CW'(1);
                    end
                    state_next = S_WRITE;
                end else if (func_reg >= FN_TRANSLATE && func_reg <= FN_FRUSTUM) begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                        state_next  = S_RSTART;
                    end else if ((func_reg == FN_ORTHO || func_reg == FN_FRUSTUM)
                                 && sts.zero_div) begin
                        status_next = ST_ZERO_DIV;
                        state_next  = S_RSTART;
                    end else begin
                        state_next = S_LOAD;
                    end
                end else if (is_push) begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                        state_next  = S_RSTART;
                    end else if (cur_cnt == CW'(STACK_DEPTH)) begin
                        status_next = ST_FULL;
                        state_next  = S_RSTART;
                    end else begin
                        state_next = S_LOAD;
                    end
                end else begin
                    state_next = S_RSTART;
                end
            end
            S_LOAD: begin
                if (idx_reg[3:0] == ELEM_LAST) begin
                    idx_next   = '0;
                    state_next = is_push ? S_WRITE : S_BASE;
                end else begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            S_BASE: begin
                sel_next = '0;
                if (func_reg == FN_FRUSTUM) begin
                    state_next = S_FE;
                end else if (func_reg == FN_ORTHO) begin
                    state_next = S_DIVGO;
                end else begin
                    state_next = S_MAC;
                end
            end
            S_FE: begin
                state_next = S_FE2;
            end
            S_FE2: begin
                state_next = S_DIVGO;
            end
            S_DIVGO: begin
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (sts.div_done) begin
                    if (sel_reg == DIV_LAST) begin
                        idx_next   = '0;
                        state_next = S_MAC;
                    end else begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = S_DIVGO;
                    end
                end
            end
            S_MAC: begin
                if (idx_reg == MAC_LAST) begin
                    idx_next   = '0;
                    state_next = S_RSTART;
                end else begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            S_WRITE: begin
                if (idx_reg[3:0] == ELEM_LAST) begin
                    idx_next = '0;
                    if (is_push) begin
                        cnt_next[stk_reg] = cur_cnt + CW'(1);
                    end
                    state_next = S_RSTART;
                end else begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            S_RSTART: begin
                idx_next   = '0;
                state_next = empty ? S_EMIT : S_RLOAD;
            end
            S_RLOAD: begin
                if (idx_reg[3:0] == ELEM_LAST) begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    if (idx_reg[1:0] == ROW_LAST) begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 7'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.func    = func_reg;
        cmd.elem    = idx_reg[3:0];
        cmd.div_sel = sel_reg;
        cmd.row     = idx_reg[1:0];
        cmd.mul_idx = idx_reg[5:0];
        cmd.wr_src  = is_push ? WR_COPY : WR_IDENT;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_LOAD, S_RLOAD: cmd.rd_en = 1'b1;
            S_WRITE: cmd.wr_en = 1'b1;
            S_BASE: cmd.base_en = 1'b1;
            S_FE: cmd.mul_fe = 1'b1;
            S_DIVGO: cmd.div_start = 1'b1;
            S_MAC: cmd.mul_en = ~idx_reg[6];
            S_RSTART: cmd.t_zero = empty;
            S_EMIT: m_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign m_row_index = idx_reg[1:0];
    assign m_last_row  = (idx_reg[1:0] == ROW_LAST);
    assign m_status    = status_reg;

    `TMSU_ASSERT_NEVER(a_ready_valid_excl, aclk, aresetn, s_ready && m_valid)
    `TMSU_ASSERT_NEVER(a_model_cnt_range, aclk, aresetn, cnt_reg[0] > CW'(STACK_DEPTH))
    `TMSU_ASSERT_NEVER(a_proj_cnt_range, aclk, aresetn, cnt_reg[1] > CW'(STACK_DEPTH))
    `TMSU_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_valid && m_ready && m_last_row, s_ready)

endmodule

// ===== rtl/transform_matrix_stack_unit_core.sv =====
// one request at a time; result rows follow, one row per cycle while m_ready is high
// the translate and scale results are set by 64 serial multiply-accumulates
// ortho and frustum also run six divisions, one quotient bit per cycle
// unused codes and rejected requests go straight to the result rows, all zero on an empty stack
// synchronous active-low reset empties both stacks; stack memories are not cleared
module transform_matrix_stack_unit_core import tmsu_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic               s_which_stack,
    input  logic signed [31:0] s_arg_a,
    input  logic signed [31:0] s_arg_b,
    input  logic signed [31:0] s_arg_c,
    input  logic signed [31:0] s_arg_d,
    input  logic signed [31:0] s_arg_e,
    input  logic signed [31:0] s_arg_f,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_col_zero,
    output logic signed [31:0] m_col_one,
    output logic signed [31:0] m_col_two,
    output logic signed [31:0] m_col_three,
    output logic               m_last_row,
    output logic [1:0]         m_status
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    dp_cmd_t       cmd;
    dp_sts_t       sts;
    logic          stk;
    logic [SW-1:0] rd_slot;
    logic [SW-1:0] wr_slot;

    tmsu_ctrl #(.STACK_DEPTH(STACK_DEPTH), .SW(SW), .CW(CW)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_which_stack(s_which_stack),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_last_row   (m_last_row),
        .m_status     (m_status),
        .cmd          (cmd),
        .sts          (sts),
        .stk          (stk),
        .rd_slot      (rd_slot),
        .wr_slot      (wr_slot)
    );

    tmsu_dp #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_arg_a    (s_arg_a),
        .s_arg_b    (s_arg_b),
        .s_arg_c    (s_arg_c),
        .s_arg_d    (s_arg_d),
        .s_arg_e    (s_arg_e),
        .s_arg_f    (s_arg_f),
        .cmd        (cmd),
        .stk        (stk),
        .rd_slot    (rd_slot),
        .wr_slot    (wr_slot),
        .sts        (sts),
        .m_col_zero (m_col_zero),
        .m_col_one  (m_col_one),
        .m_col_two  (m_col_two),
        .m_col_three(m_col_three)
    );

endmodule
